// File: rtl/lap5_pkg.sv
// Shared types and constants of the 5x5 Laplacian-of-Gaussian edge marker.
package lap5_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int THR_W      = 12;
    localparam int SUM_W      = 12;
    localparam int KSIZE      = 5;
    localparam int MAX_HEIGHT = 4096;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [THR_W-1:0]    THR_RST    = 12'd2;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_THRESH = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [WIDTH_W-1:0]  image_width;
        logic [HEIGHT_W-1:0] image_height;
        logic [THR_W-1:0]    zero_threshold;
    } t_cfg;

    typedef struct packed {
        logic             emit;
        logic             inner;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_info;

    typedef struct packed {
        logic  valid;
        t_info info;
    } t_stage;

    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] t_window;

endpackage

// File: rtl/lap5_apb_regs.sv
// Configuration registers of the edge marker behind an APB-style port.
module lap5_apb_regs
    import lap5_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width    <= WIDTH_RST;
            r_cfg.image_height   <= HEIGHT_RST;
            r_cfg.zero_threshold <= THR_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH:  r_cfg.image_width    <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: r_cfg.image_height   <= pwdata[HEIGHT_W-1:0];
                REG_THRESH: r_cfg.zero_threshold <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(r_cfg.image_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_cfg.image_height);
            REG_THRESH: prdata = APB_DATA_W'(r_cfg.zero_threshold);
            default:    prdata = '0;
        endcase
    end

endmodule

// File: rtl/lap5_line_buf.sv
// Raster counters, line store memory with its clearing pass, and the 5x5 window.
module lap5_line_buf
    import lap5_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int BORDER    = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_pixel_valid,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_pixel_stall,
    input  logic             i_advance,
    output t_stage           o_stage,
    output t_window          o_window
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CX  = WW + 1;
    localparam int MW  = 4 * PIX_W;

    // Line store: byte 3 of a word holds the newest stored row of its column, byte 0
    // the oldest.
    logic [MW-1:0]       mem [MAX_WIDTH];
    logic [MW-1:0]       r_rd_data;
    logic                r_byp;
    logic [MW-1:0]       r_byp_data;

    logic                r_clearing;
    logic [CW-1:0]       r_clr_cnt;

    logic [ROW_W-1:0]    r_row_cnt;
    logic [CW-1:0]       r_col_cnt;
    logic [ROW_W-1:0]    n_row_cnt;
    logic [CW-1:0]       n_col_cnt;

    logic                r_v1;
    t_info               r_info1;
    logic [PIX_W-1:0]    r_pix1;
    logic [CW-1:0]       r_addr1;

    t_stage              r_s2;
    t_window             r_win;

    logic [WW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic                en1;
    logic                accept;
    logic                s1_move;
    t_info               info0;
    logic [ROW_W-1:0]    cr;
    logic [CW-1:0]       cc;
    logic [WW-1:0]       c_inc;
    logic [HEIGHT_W-1:0] r_inc;
    logic [MW-1:0]       mem_word;
    logic [KSIZE-1:0][PIX_W-1:0] col;
    logic                mem_we;
    logic [CW-1:0]       mem_wa;
    logic [MW-1:0]       mem_wd;
    logic [MW-1:0]       col_wd;

    always_comb begin
        if (i_cfg.image_width == '0) begin
            eff_w = WW'(1);
        end else if (int'(i_cfg.image_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            eff_h = HEIGHT_W'(1);
        end else if (int'(i_cfg.image_height) > MAX_HEIGHT) begin
            eff_h = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            eff_h = i_cfg.image_height;
        end
    end

    assign en1           = !r_v1 || i_advance;
    assign accept        = i_pixel_valid && en1 && !r_clearing;
    assign o_pixel_stall = r_clearing || !en1;
    assign s1_move       = r_v1 && i_advance;

    // Position and border decisions for the center two rows up and two columns left.
    always_comb begin
        cr    = r_row_cnt - ROW_W'(2);
        cc    = r_col_cnt - CW'(2);
        c_inc = WW'(r_col_cnt) + WW'(1);
        r_inc = HEIGHT_W'(r_row_cnt) + HEIGHT_W'(1);

        info0.emit  = (r_row_cnt >= ROW_W'(2)) && (r_col_cnt >= CW'(2));
        info0.inner = (cr >= ROW_W'(BORDER)) && (cc >= CW'(BORDER)) &&
                      (HEIGHT_W'(cr) + HEIGHT_W'(BORDER) < eff_h) &&
                      (CX'(cc) + CX'(BORDER) < CX'(eff_w));
        info0.last  = (r_inc == eff_h) && (c_inc == eff_w);
        info0.row   = cr;
        info0.col   = COL_W'(cc);

        if (c_inc >= eff_w) begin
            n_col_cnt = '0;
            n_row_cnt = (r_inc >= eff_h) ? '0 : ROW_W'(r_inc);
        end else begin
            n_col_cnt = CW'(c_inc);
            n_row_cnt = (HEIGHT_W'(r_row_cnt) >= eff_h) ? '0 : r_row_cnt;
        end
    end

    // New window column, oldest row first, and the shifted word written back.
    always_comb begin
        mem_word = r_byp ? r_byp_data : r_rd_data;
        for (int i = 0; i < 4; i++) begin
            col[i] = mem_word[i*PIX_W +: PIX_W];
        end
        col[4] = r_pix1;
        for (int i = 0; i < 4; i++) begin
            col_wd[i*PIX_W +: PIX_W] = col[i+1];
        end
        mem_we = r_clearing || s1_move;
        mem_wa = r_clearing ? r_clr_cnt : r_addr1;
        mem_wd = r_clearing ? '0 : col_wd;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            r_rd_data <= mem[r_col_cnt];
        end
    end

    // Same-column write in the cycle of the read: forward the written word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp      <= s1_move && (r_addr1 == r_col_cnt);
            r_byp_data <= col_wd;
            r_pix1     <= i_pixel;
            r_addr1    <= r_col_cnt;
            r_info1    <= info0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_row_cnt  <= '0;
            r_col_cnt  <= '0;
            r_v1       <= 1'b0;
            r_s2       <= '0;
            r_win      <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + CW'(1);
                if (r_clr_cnt == CW'(MAX_WIDTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_row_cnt <= n_row_cnt;
                r_col_cnt <= n_col_cnt;
            end
            if (en1) begin
                r_v1 <= accept;
            end
            if (i_advance) begin
                r_s2.valid <= r_v1;
            end
            if (s1_move) begin
                r_s2.info <= r_info1;
                for (int i = 0; i < KSIZE; i++) begin
                    for (int j = 0; j < KSIZE - 1; j++) begin
                        r_win[i][j] <= r_win[i][j+1];
                    end
                    r_win[i][KSIZE-1] <= col[i];
                end
            end
        end
    end

    assign o_stage  = r_s2;
    assign o_window = r_win;

endmodule

// File: rtl/lap5_kernel.sv
// Kernel sum, magnitude threshold and the result register of the edge marker.
module lap5_kernel
    import lap5_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stage            i_stage,
    input  t_window           i_window,
    input  logic [THR_W-1:0]  i_threshold,
    output logic              o_advance,
    output logic              o_result_valid,
    input  logic              i_result_stall,
    output logic [PIX_W-1:0]  o_edge_pixel,
    output logic [ROW_W-1:0]  o_out_row,
    output logic [COL_W-1:0]  o_out_col,
    output logic              o_frame_last
);

    logic              r_v3;
    t_info             r_info3;
    logic [SUM_W-1:0]  r_pos;
    logic [PIX_W-1:0]  r_ctr;

    logic              r_o_valid;
    logic [PIX_W-1:0]  r_edge;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic              r_last;

    logic              en_out;
    logic              en3;
    logic [SUM_W-1:0]  pos;
    logic signed [SUM_W:0] diff;
    logic [SUM_W-1:0]  mag;

    assign en_out    = !r_o_valid || !i_result_stall;
    assign en3       = !r_v3 || en_out;
    assign o_advance = !i_stage.valid || en3;

    // Positive taps of the kernel: four ones at distance two, four diagonal ones,
    // four direct neighbors of weight two.
    always_comb begin
        pos = SUM_W'(i_window[0][2]) + SUM_W'(i_window[4][2]) +
              SUM_W'(i_window[2][0]) + SUM_W'(i_window[2][4]) +
              SUM_W'(i_window[1][1]) + SUM_W'(i_window[1][3]) +
              SUM_W'(i_window[3][1]) + SUM_W'(i_window[3][3]) +
              SUM_W'({i_window[1][2], 1'b0}) + SUM_W'({i_window[3][2], 1'b0}) +
              SUM_W'({i_window[2][1], 1'b0}) + SUM_W'({i_window[2][3], 1'b0});
    end

    always_comb begin
        diff = $signed({1'b0, r_pos}) - $signed({1'b0, r_ctr, 4'b0000});
        mag  = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en3 && i_stage.valid) begin
            r_info3 <= i_stage.info;
            r_pos   <= pos;
            r_ctr   <= i_window[2][2];
        end
        if (en_out && r_v3) begin
            r_edge <= (r_info3.inner && (mag < i_threshold)) ? EDGE_ON : EDGE_OFF;
            r_row  <= r_info3.row;
            r_col  <= r_info3.col;
            r_last <= r_info3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= i_stage.valid;
            end
            if (en_out) begin
                r_o_valid <= r_v3 && r_info3.emit;
            end
        end
    end

    assign o_result_valid = r_o_valid;
    assign o_edge_pixel   = r_edge;
    assign o_out_row      = r_row;
    assign o_out_col      = r_col;
    assign o_frame_last   = r_last;

endmodule

// File: rtl/laplacian_5x5_edge_threshold.sv
// Top level of the streaming 5x5 Laplacian-of-Gaussian edge marker.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+---------------------------------------
//  pixel in | i_pixel_valid / o_pixel_stall    | i_pixel
//  result   | o_result_valid / i_result_stall  | o_edge_pixel, o_out_row, o_out_col,
//           |                                  | o_frame_last
//  config   | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// The block takes one pixel request every clock while o_pixel_stall is low; the line
// store memory does one read and one write each cycle; that single port pair sets the rate.
// A taken pixel passes the stage-1, window and sum registers into the result register.
// After reset a clearing pass zeroes the line store, one column word per clock, over all
// MAX_WIDTH words; o_pixel_stall stays high during it, configuration writes still work.
// A stalled result holds in the output register while the stages behind it keep
// filling; past the clearing pass, o_pixel_stall rises only once every stage is full.
module laplacian_5x5_edge_threshold
    import lap5_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int BORDER    = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_pixel_valid,
    output logic                  o_pixel_stall,
    input  logic [PIX_W-1:0]      i_pixel,

    output logic                  o_result_valid,
    input  logic                  i_result_stall,
    output logic [PIX_W-1:0]      o_edge_pixel,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [COL_W-1:0]      o_out_col,
    output logic                  o_frame_last,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    cfg;
    t_stage  win_stage;
    t_window window;
    logic    win_advance;

    // Register bank: width, height and threshold take effect at once.
    lap5_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Raster counters, line store and window. Each accepted pixel reads the four
    // stored rows of its column, pushes itself in, and shifts a new column into
    // the 5x5 window together with the position and border flags of its center.
    lap5_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .BORDER    (BORDER)
    ) u_line_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_pixel_valid (i_pixel_valid),
        .i_pixel       (i_pixel),
        .o_pixel_stall (o_pixel_stall),
        .i_advance     (win_advance),
        .o_stage       (win_stage),
        .o_window      (window)
    );

    // Adder tree over the window, then the magnitude compare into the result register.
    // Pixels whose center is not yet two rows and two columns in are dropped here.
    lap5_kernel u_kernel (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stage        (win_stage),
        .i_window       (window),
        .i_threshold    (cfg.zero_threshold),
        .o_advance      (win_advance),
        .o_result_valid (o_result_valid),
        .i_result_stall (i_result_stall),
        .o_edge_pixel   (o_edge_pixel),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_frame_last   (o_frame_last)
    );

endmodule

// File: rtl/lap5_checker.sv
// Port-level assertions for the edge marker and the bind that attaches them.
module lap5_checker
    import lap5_pkg::*;
#(
    parameter int BORDER = 5
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_result_valid,
    input logic             i_result_stall,
    input logic [PIX_W-1:0] o_edge_pixel,
    input logic [ROW_W-1:0] o_out_row,
    input logic [COL_W-1:0] o_out_col,
    input logic             o_frame_last,
    input logic             pready
);

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && i_result_stall |=>
            o_result_valid && $stable(o_edge_pixel) && $stable(o_out_row) &&
            $stable(o_out_col) && $stable(o_frame_last))
        else $error("stalled result changed");

    a_edge_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_edge_pixel == EDGE_ON || o_edge_pixel == EDGE_OFF))
        else $error("edge pixel is neither 0 nor 255");

    a_last_is_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_frame_last |-> o_edge_pixel == EDGE_OFF)
        else $error("last result of a frame marked as edge");

    a_left_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_out_col < COL_W'(BORDER)) |-> o_edge_pixel == EDGE_OFF)
        else $error("left border centre marked as edge");

    a_top_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_out_row < ROW_W'(BORDER)) |-> o_edge_pixel == EDGE_OFF &&
            pready)
        else $error("top border centre marked as edge");

endmodule

bind laplacian_5x5_edge_threshold lap5_checker #(
    .BORDER (BORDER)
) u_lap5_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_result_valid (o_result_valid),
    .i_result_stall (i_result_stall),
    .o_edge_pixel   (o_edge_pixel),
    .o_out_row      (o_out_row),
    .o_out_col      (o_out_col),
    .o_frame_last   (o_frame_last),
    .pready         (pready)
);

// File: tb/laplacian_5x5_edge_threshold_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the streaming 5x5 Laplacian-of-Gaussian edge marker.
module laplacian_5x5_edge_threshold_tb;
    import lap5_pkg::*;

    // Block parameters, kept at the values the block is built with.
    localparam int LINE_MAX      = 2048;
    localparam int EDGE_BORDER   = 5;

    // Settling time after the last result, long enough for pixels that only fill the
    // pipeline without a result to pass through.
    localparam int SETTLE_CYCLES = 12;

    // Longest stretch without any accepted request.  The clearing pass after reset
    // alone holds the pixel channel while it zeroes all LINE_MAX words of the line store.
    localparam int STALL_LIMIT   = 20000;

    // Least pixel count of the whole run; the random frames go on until it is reached.
    localparam int TOTAL_ITEMS   = 1750;

    // Image content used to build frames.
    typedef enum int {
        PAT_NOISE,
        PAT_FLAT,
        PAT_RAMP,
        PAT_SPOT,
        PAT_BLOCKS
    } t_pattern;

    typedef struct packed {
        logic [PIX_W-1:0] edge_pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             frame_last;
    } t_edge_result;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  pixel_valid  = 1'b0;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      pixel_in     = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [PIX_W-1:0]      edge_pixel;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  frame_last;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the block: four line stores, the 5x5 neighborhood, the position of
    // the next pixel and the three registers.
    logic [PIX_W-1:0]    line_rows [4][LINE_MAX];
    logic [PIX_W-1:0]    nbhd [5][5];
    int unsigned         next_row;
    int unsigned         next_col;
    logic [WIDTH_W-1:0]  reg_width;
    logic [HEIGHT_W-1:0] reg_height;
    logic [THR_W-1:0]    reg_thresh;

    // Edge marks predicted but not yet seen on the result channel.
    t_edge_result pending_edges [$];

    int unsigned pixels_taken = 0;
    int          errors       = 0;
    int          idle_cycles  = 0;

    // When set, neither side idles: the pixel source sends every clock and the
    // result sink never stalls.
    bit calm = 1'b0;

    // Frame content knobs.
    logic [PIX_W-1:0] pat_base      = '0;
    int unsigned      pat_slope_r   = 0;
    int unsigned      pat_slope_c   = 0;
    int unsigned      pat_spot_r    = 5;
    int unsigned      pat_spot_c    = 5;
    logic [PIX_W-1:0] pat_spot_val  = '0;
    int unsigned      pat_block     = 1;

    laplacian_5x5_edge_threshold #(
        .MAX_WIDTH (LINE_MAX),
        .BORDER    (EDGE_BORDER)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_pixel_valid  (pixel_valid),
        .o_pixel_stall  (pixel_stall),
        .i_pixel        (pixel_in),
        .o_result_valid (result_valid),
        .i_result_stall (result_stall),
        .o_edge_pixel   (edge_pixel),
        .o_out_row      (out_row),
        .o_out_col      (out_col),
        .o_frame_last   (frame_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The result sink stalls about a quarter of the clocks, except in calm stretches.
    always @(posedge clk) begin
        result_stall <= !calm && ($urandom_range(99) < 24);
    end

    // Predict what one accepted pixel does: shift the line stores and the window,
    // and, once two rows and two columns are in, mark the center two rows up and
    // two columns left of it.
    task automatic predict_edge_mark(input logic [PIX_W-1:0] px);
        logic [PIX_W-1:0] column [5];
        int unsigned      w, h, r, c, ci, cr, cc, mag;
        int               pos, sum, i, j;
        bit               inner;
        t_edge_result     res;
        w = (reg_width == 0) ? 1 : ((reg_width > LINE_MAX) ? LINE_MAX : reg_width);
        h = (reg_height == 0) ? 1 : ((reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height);
        r = next_row;
        c = next_col;
        ci = c % LINE_MAX;

        for (i = 0; i < 4; i++) column[i] = line_rows[i][ci];
        column[4] = px;
        for (i = 0; i < 3; i++) line_rows[i][ci] = column[i + 1];
        line_rows[3][ci] = px;
        for (i = 0; i < 5; i++) begin
            for (j = 0; j < 4; j++) nbhd[i][j] = nbhd[i][j + 1];
            nbhd[i][4] = column[i];
        end

        if (r >= 2 && c >= 2) begin
            cr = r - 2;
            cc = c - 2;
            inner = cr >= EDGE_BORDER && cc >= EDGE_BORDER &&
                    cr + EDGE_BORDER < h && cc + EDGE_BORDER < w;
            res.edge_pixel = EDGE_OFF;
            if (inner) begin
                // Four ones on the outer ring, inner ring of ones and twos, center -16.
                pos = nbhd[0][2] + nbhd[4][2] + nbhd[2][0] + nbhd[2][4]
                    + nbhd[1][1] + nbhd[1][3] + nbhd[3][1] + nbhd[3][3]
                    + 2 * (nbhd[1][2] + nbhd[3][2] + nbhd[2][1] + nbhd[2][3]);
                sum = pos - 16 * int'(nbhd[2][2]);
                mag = (sum < 0) ? -sum : sum;
                if (mag < reg_thresh) res.edge_pixel = EDGE_ON;
            end
            res.row = ROW_W'(cr);
            res.col = COL_W'(cc);
            res.frame_last = (r + 1 == h) && (c + 1 == w);
            pending_edges.push_back(res);
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end else if (r >= h) begin
            r = 0;
        end
        next_row = r;
        next_col = c;
    endtask

    // Send one pixel request, with random idle clocks ahead of it, and wait until the
    // block takes it.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while (!calm && $urandom_range(99) < 24) begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_in    <= px;
        @(posedge clk);
        while (pixel_stall) @(posedge clk);
        predict_edge_mark(px);
        pixels_taken++;
    endtask

    // Hold the pixel source until every predicted mark has arrived, then let the
    // pipeline empty out behind the last one.
    task automatic wait_results_done();
        pixel_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB write: a setup phase, then an access phase that ends with the write,
    // then an idle phase before the next transfer.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  reg_width  = value[WIDTH_W-1:0];
            REG_HEIGHT: reg_height = value[HEIGHT_W-1:0];
            default:    reg_thresh = value[THR_W-1:0];
        endcase
        @(posedge clk);
    endtask

    // Registers are only changed with the block drained.
    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned thr);
        wait_results_done();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_THRESH, thr);
    endtask

    function automatic logic [PIX_W-1:0] pattern_pixel(input t_pattern pat,
                                                       input int unsigned r,
                                                       input int unsigned c);
        case (pat)
            PAT_FLAT:   return pat_base + PIX_W'($urandom_range(3));
            PAT_RAMP:   return PIX_W'(pat_base + pat_slope_r * r + pat_slope_c * c);
            PAT_SPOT:   return (r == pat_spot_r && c == pat_spot_c) ? pat_spot_val
                                                                    : ~pat_spot_val;
            PAT_BLOCKS: return (((r / pat_block) ^ (c / pat_block)) & 1) ? EDGE_ON
                                                                         : EDGE_OFF;
            default:    return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Send pixels of the given content until the frame wraps back to its first pixel.
    task automatic send_frame_rest(input t_pattern pat);
        do begin
            send_pixel(pattern_pixel(pat, next_row, next_col));
        end while (next_row != 0 || next_col != 0);
    endtask

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    // Every accepted result is checked against the oldest predicted mark.
    always @(posedge clk) begin
        t_edge_result want;
        if (rst_n && result_valid && !result_stall) begin
            if (pending_edges.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual row %0d col %0d",
                         $time, out_row, out_col);
            end else begin
                want = pending_edges.pop_front();
                if (edge_pixel !== want.edge_pixel)
                    flag_mismatch("edge_pixel", want.edge_pixel, edge_pixel);
                if (out_row !== want.row)
                    flag_mismatch("out_row", want.row, out_row);
                if (out_col !== want.col)
                    flag_mismatch("out_col", want.col, out_col);
                if (frame_last !== want.frame_last)
                    flag_mismatch("frame_last", want.frame_last, frame_last);
            end
        end
    end

    // Watchdog: ends the run when no request moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no request accepted for %0d clocks", $time, idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reset_model();
        int i, j;
        for (i = 0; i < 4; i++)
            for (j = 0; j < LINE_MAX; j++) line_rows[i][j] = '0;
        for (i = 0; i < 5; i++)
            for (j = 0; j < 5; j++) nbhd[i][j] = '0;
        next_row   = 0;
        next_col   = 0;
        reg_width  = WIDTH_RST;
        reg_height = HEIGHT_RST;
        reg_thresh = THR_RST;
    endtask

    // The registers keep their reset values; the first rows of a 640 pixel wide image
    // cannot yet produce any result.
    task automatic test_reset_defaults();
        repeat (12) send_pixel(PIX_W'($urandom_range(255)));
    endtask

    // Degenerate sizes: zero width and height clamp to one, images narrower or
    // shorter than three emit nothing, and a 3x3 image emits one border center.
    task automatic test_tiny_images();
        set_geometry(0, 0, 4095);
        repeat (4) send_pixel(PIX_W'($urandom_range(255)));
        set_geometry(2, 6, 4095);
        repeat (8) send_pixel(PIX_W'($urandom_range(255)));
        set_geometry(5, 2, 4095);
        repeat (6) send_pixel(PIX_W'($urandom_range(255)));
        set_geometry(3, 3, 4095);
        pat_block = 1;
        send_frame_rest(PAT_NOISE);
        send_frame_rest(PAT_BLOCKS);
    endtask

    // The largest possible kernel sums on the single inner center of an 11x11 image,
    // against a threshold just above them and one equal to them, and a flat image against a
    // threshold of zero and of one.
    task automatic test_kernel_extremes();
        set_geometry(11, 11, 4081);
        send_frame_rest(PAT_NOISE);
        pat_spot_r   = 5;
        pat_spot_c   = 5;
        pat_spot_val = 8'd0;
        send_frame_rest(PAT_SPOT);
        set_geometry(11, 11, 4080);
        pat_spot_val = 8'd255;
        send_frame_rest(PAT_SPOT);
        pat_slope_r = 0;
        pat_slope_c = 0;
        pat_base    = PIX_W'($urandom_range(255));
        set_geometry(11, 11, 0);
        send_frame_rest(PAT_RAMP);
        set_geometry(11, 11, 1);
        send_frame_rest(PAT_RAMP);
    endtask

    // Back-to-back traffic: a pixel every clock and a sink that never stalls.
    task automatic test_full_rate();
        set_geometry(16, 12, 24);
        calm = 1'b1;
        pat_base = PIX_W'($urandom_range(200));
        send_frame_rest(PAT_FLAT);
        send_frame_rest(PAT_FLAT);
        calm = 1'b0;
    endtask

    // Register writes in the middle of a frame take effect at once: a width or height
    // beyond range is clamped, and a counter left beyond a new, smaller limit wraps.
    task automatic test_mid_frame_changes();
        set_geometry(20, 30, 40);
        pat_base = PIX_W'($urandom_range(200));
        repeat (70) send_pixel(pattern_pixel(PAT_FLAT, next_row, next_col));
        set_geometry(4095, 8191, 40);
        repeat (60) send_pixel(pattern_pixel(PAT_FLAT, next_row, next_col));
        set_geometry(12, 8191, 40);
        repeat (30) send_pixel(pattern_pixel(PAT_FLAT, next_row, next_col));
        set_geometry(12, 40, 40);
        repeat (120) send_pixel(pattern_pixel(PAT_FLAT, next_row, next_col));
        set_geometry(12, 12, 40);
        send_frame_rest(PAT_FLAT);
        // The source holds off mid-frame until every mark is out, then goes on.
        repeat (50) send_pixel(pattern_pixel(PAT_FLAT, next_row, next_col));
        wait_results_done();
        pat_slope_r = 3;
        pat_slope_c = 5;
        send_frame_rest(PAT_RAMP);
    endtask

    // Random image sizes, thresholds and content, mostly as whole frames, with some
    // frames cut short by a register change, until the run reaches its pixel count.
    task automatic test_random_frames();
        int unsigned w, h, thr, nframes;
        t_pattern    pat;
        do begin
            w = ($urandom_range(9) == 0) ? $urandom_range(3, 10) : $urandom_range(11, 20);
            h = ($urandom_range(9) == 0) ? $urandom_range(3, 10) : $urandom_range(11, 16);
            case ($urandom_range(5))
                0:       thr = 0;
                1:       thr = $urandom_range(1, 8);
                2:       thr = $urandom_range(8, 200);
                3:       thr = $urandom_range(4095);
                4:       thr = $urandom_range(4080, 4081);
                default: thr = 4095;
            endcase
            set_geometry(w, h, thr);
            nframes = $urandom_range(1, 2);
            repeat (nframes) begin
                pat          = t_pattern'($urandom_range(4));
                pat_base     = PIX_W'($urandom_range(255));
                pat_slope_r  = $urandom_range(9);
                pat_slope_c  = $urandom_range(9);
                pat_spot_r   = $urandom_range(h - 1);
                pat_spot_c   = $urandom_range(w - 1);
                pat_spot_val = $urandom_range(1) ? 8'd255 : 8'd0;
                pat_block    = $urandom_range(1, 4);
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(1, 40))
                        send_pixel(pattern_pixel(pat, next_row, next_col));
                    wait_results_done();
                end
                send_frame_rest(pat);
            end
            // Leave the frame unfinished so that the next write lands mid-frame.
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, w * h - 1))
                    send_pixel(PIX_W'($urandom_range(255)));
        end while (pixels_taken < TOTAL_ITEMS);
    endtask

    initial begin
        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_tiny_images();
        test_kernel_extremes();
        test_full_rate();
        test_mid_frame_changes();
        test_random_frames();

        wait_results_done();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
